// ===== hdl/gcsp_pkg.sv =====
package gcsp_pkg;

    // Store geometry
    localparam int MAX_DIM          = 64;
    localparam int MAX_IN_CHANNELS  = 16;
    localparam int MAX_OUT_CHANNELS = 16;
    localparam int MAX_KERNEL       = 7;

    localparam int FEAT_DEPTH = MAX_IN_CHANNELS * MAX_DIM * MAX_DIM;
    localparam int WGT_DEPTH  = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int FEAT_AW    = $clog2(FEAT_DEPTH);
    localparam int WGT_AW     = $clog2(WGT_DEPTH);

    // Single precision codes
    localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
    localparam logic [31:0] INF32  = 32'h7F80_0000;

    typedef enum logic [1:0] {
        REQ_SAMPLE  = 2'd0,
        REQ_WEIGHT  = 2'd1,
        REQ_BIAS    = 2'd2,
        REQ_COMPUTE = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_KERNEL_WIDTH  = 3'd2,
        CFG_KERNEL_HEIGHT = 3'd3,
        CFG_PAD_LEFT      = 3'd4,
        CFG_PAD_TOP       = 3'd5,
        CFG_IN_PER_GROUP  = 3'd6,
        CFG_OUT_PER_GROUP = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FETCH,
        ST_FEED,
        ST_WAIT,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] result;
    } fma_out_t;

    // Position of the highest set bit, zero for zero
    function automatic logic [5:0] top_bit64(input logic [63:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    // Flat weight address of (out chan, in-group chan, kernel row, kernel col)
    function automatic logic [WGT_AW-1:0] wgt_addr(input logic [3:0] oc, input logic [3:0] gc,
                                                   input logic [2:0] kr, input logic [2:0] kc);
        logic [WGT_AW+3:0] a;
        a = (WGT_AW+4)'({oc, gc}) * (WGT_AW+4)'(MAX_KERNEL * MAX_KERNEL)
            + (WGT_AW+4)'(kr) * (WGT_AW+4)'(MAX_KERNEL) + (WGT_AW+4)'(kc);
        return a[WGT_AW-1:0];
    endfunction

endpackage

// ===== hdl/gcsp_ram.sv =====
module gcsp_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/gcsp_fma.sv =====
module gcsp_fma import gcsp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic [31:0] in_a,
    input  logic [31:0] in_b,
    input  logic [31:0] in_c,
    output fma_out_t    fma_out
);

    // stage 1: unpack, specials, multiply, normalize addend
    logic        sa, sb, sc, sp;
    logic [7:0]  ea, eb, ec, eadj_a, eadj_b, eadj_c;
    logic [22:0] fa, fb, fc;
    logic        az, bz, cz, anan, bnan, cnan;
    logic [23:0] ma, mb, mc;
    logic [5:0]  tc, ncm;
    logic        spec;
    logic [31:0] spec_res;

    logic              s1_valid_reg, s1_spec_reg, s1_sp_reg, s1_sc_reg, s1_cz_reg;
    logic [31:0]       s1_res_reg;
    logic [47:0]       s1_pm_reg;
    logic signed [12:0] s1_xp_reg, s1_xc_reg;
    logic [63:0]       s1_cm_reg;

    always_comb begin
        sa = in_a[31]; sb = in_b[31]; sc = in_c[31]; sp = sa ^ sb;
        ea = in_a[30:23]; eb = in_b[30:23]; ec = in_c[30:23];
        fa = in_a[22:0]; fb = in_b[22:0]; fc = in_c[22:0];
        az = (ea == 8'd0) && (fa == 23'd0);
        bz = (eb == 8'd0) && (fb == 23'd0);
        cz = (ec == 8'd0) && (fc == 23'd0);
        anan = (ea == 8'hFF) && (fa != 23'd0);
        bnan = (eb == 8'hFF) && (fb != 23'd0);
        cnan = (ec == 8'hFF) && (fc != 23'd0);
        eadj_a = (ea != 8'd0) ? ea : 8'd1;
        eadj_b = (eb != 8'd0) ? eb : 8'd1;
        eadj_c = (ec != 8'd0) ? ec : 8'd1;
        ma = {ea != 8'd0, fa};
        mb = {eb != 8'd0, fb};
        mc = {ec != 8'd0, fc};
        tc = top_bit64({40'd0, mc});
        ncm = 6'd61 - tc;

        spec = 1'b1;
        spec_res = QNAN32;
        if (anan || bnan || cnan) begin
            spec_res = QNAN32;
        end else if (ea == 8'hFF || eb == 8'hFF) begin
            if (az || bz || (ec == 8'hFF && sc != sp)) begin
                spec_res = QNAN32;
            end else begin
                spec_res = {sp, INF32[30:0]};
            end
        end else if (ec == 8'hFF) begin
            spec_res = in_c;
        end else if (az || bz) begin
            spec_res = cz ? {sp & sc, 31'd0} : in_c;
        end else begin
            spec = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
        end
        s1_spec_reg <= spec;
        s1_res_reg  <= spec_res;
        s1_sp_reg   <= sp;
        s1_sc_reg   <= sc;
        s1_cz_reg   <= cz;
        s1_pm_reg   <= 48'(ma) * 48'(mb);
        s1_xp_reg   <= $signed({5'd0, eadj_a}) + $signed({5'd0, eadj_b}) - 13'sd300;
        s1_cm_reg   <= {40'd0, mc} << ncm;
        s1_xc_reg   <= $signed({5'd0, eadj_c}) - 13'sd150 - $signed({7'd0, ncm});
    end

    // stage 2: normalize product
    logic [5:0] tp, npm;
    logic              s2_valid_reg, s2_spec_reg, s2_sp_reg, s2_sc_reg, s2_cz_reg;
    logic [31:0]       s2_res_reg;
    logic [63:0]       s2_pm_reg, s2_cm_reg;
    logic signed [12:0] s2_xp_reg, s2_xc_reg;

    always_comb begin
        tp  = top_bit64({16'd0, s1_pm_reg});
        npm = 6'd61 - tp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
        s2_spec_reg <= s1_spec_reg;
        s2_res_reg  <= s1_res_reg;
        s2_sp_reg   <= s1_sp_reg;
        s2_sc_reg   <= s1_sc_reg;
        s2_cz_reg   <= s1_cz_reg;
        s2_pm_reg   <= {16'd0, s1_pm_reg} << npm;
        s2_xp_reg   <= s1_xp_reg - $signed({7'd0, npm});
        s2_cm_reg   <= s1_cm_reg;
        s2_xc_reg   <= s1_xc_reg;
    end

    // stage 3: order operands, align smaller with sticky
    logic              pick_p, sbig, ssmall;
    logic [63:0]       big, small_v, small_al;
    logic signed [12:0] xb, xs, d;
    logic [5:0]        dsh;

    logic              s3_valid_reg, s3_spec_reg, s3_sbig_reg, s3_ssmall_reg;
    logic [31:0]       s3_res_reg;
    logic [63:0]       s3_big_reg, s3_small_reg;
    logic signed [12:0] s3_xb_reg;

    always_comb begin
        pick_p  = s2_cz_reg || (s2_xp_reg >= s2_xc_reg);
        big     = pick_p ? s2_pm_reg : s2_cm_reg;
        small_v = pick_p ? (s2_cz_reg ? 64'd0 : s2_cm_reg) : s2_pm_reg;
        xb      = pick_p ? s2_xp_reg : s2_xc_reg;
        xs      = pick_p ? s2_xc_reg : s2_xp_reg;
        sbig    = pick_p ? s2_sp_reg : s2_sc_reg;
        ssmall  = pick_p ? s2_sc_reg : s2_sp_reg;
        d       = s2_cz_reg ? 13'sd0 : (xb - xs);
        dsh     = d[5:0];
        if (d >= 13'sd63) begin
            small_al = {63'd0, small_v != 64'd0};
        end else if (d > 13'sd0) begin
            small_al = (small_v >> dsh)
                     | {63'd0, (small_v & ((64'd1 << dsh) - 64'd1)) != 64'd0};
        end else begin
            small_al = small_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else begin
            s3_valid_reg <= s2_valid_reg;
        end
        s3_spec_reg   <= s2_spec_reg;
        s3_res_reg    <= s2_res_reg;
        s3_big_reg    <= big;
        s3_small_reg  <= small_al;
        s3_xb_reg     <= xb;
        s3_sbig_reg   <= sbig;
        s3_ssmall_reg <= ssmall;
    end

    // stage 4: add or subtract magnitudes
    logic [63:0] sum;
    logic        sgn;
    logic              s4_valid_reg, s4_spec_reg, s4_sgn_reg;
    logic [31:0]       s4_res_reg;
    logic [63:0]       s4_sum_reg;
    logic signed [12:0] s4_xb_reg;

    always_comb begin
        if (s3_sbig_reg == s3_ssmall_reg) begin
            sum = s3_big_reg + s3_small_reg;
            sgn = s3_sbig_reg;
        end else if (s3_big_reg >= s3_small_reg) begin
            sum = s3_big_reg - s3_small_reg;
            sgn = s3_sbig_reg;
        end else begin
            sum = s3_small_reg - s3_big_reg;
            sgn = s3_ssmall_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else begin
            s4_valid_reg <= s3_valid_reg;
        end
        s4_spec_reg <= s3_spec_reg;
        s4_res_reg  <= s3_res_reg;
        s4_sum_reg  <= sum;
        s4_sgn_reg  <= sgn;
        s4_xb_reg   <= s3_xb_reg;
    end

    // stage 5: exponent and rounding position
    logic [5:0]        ts;
    logic signed [12:0] e, eeff, sh;
    logic              s5_valid_reg, s5_spec_reg, s5_sgn_reg, s5_ovf_reg, s5_zero_reg;
    logic [31:0]       s5_res_reg;
    logic [63:0]       s5_sum_reg;
    logic [7:0]        s5_eeff_reg;
    logic signed [12:0] s5_sh_reg;

    always_comb begin
        ts   = top_bit64(s4_sum_reg);
        e    = $signed({7'd0, ts}) + s4_xb_reg + 13'sd127;
        eeff = (e < 13'sd1) ? 13'sd1 : e;
        sh   = eeff - s4_xb_reg - 13'sd150;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else begin
            s5_valid_reg <= s4_valid_reg;
        end
        s5_spec_reg <= s4_spec_reg;
        s5_res_reg  <= s4_res_reg;
        s5_sgn_reg  <= s4_sgn_reg;
        s5_sum_reg  <= s4_sum_reg;
        s5_zero_reg <= (s4_sum_reg == 64'd0);
        s5_ovf_reg  <= (e > 13'sd254);
        s5_eeff_reg <= eeff[7:0];
        s5_sh_reg   <= sh;
    end

    // stage 6: round to nearest even, pack
    logic [5:0]  shamt;
    logic signed [12:0] nsh;
    logic [63:0] q, rem, half, bits;
    logic [31:0] packed_res;
    logic        out_valid_reg;
    logic [31:0] out_result_reg;

    always_comb begin
        nsh   = -s5_sh_reg;
        shamt = s5_sh_reg[5:0];
        rem   = 64'd0;
        half  = 64'd0;
        if (s5_sh_reg <= 13'sd0) begin
            q = s5_sum_reg << nsh[5:0];
        end else if (s5_sh_reg >= 13'sd64) begin
            q = 64'd0;
        end else begin
            q    = s5_sum_reg >> shamt;
            rem  = s5_sum_reg & ((64'd1 << shamt) - 64'd1);
            half = 64'd1 << (shamt - 6'd1);
            if (rem > half || (rem == half && q[0])) begin
                q = q + 64'd1;
            end
        end
        bits = ({56'd0, s5_eeff_reg - 8'd1} << 23) + q;
        if (bits >= {32'd0, INF32}) begin
            bits = {32'd0, INF32};
        end
        if (s5_spec_reg) begin
            packed_res = s5_res_reg;
        end else if (s5_zero_reg) begin
            packed_res = 32'd0;
        end else if (s5_ovf_reg) begin
            packed_res = {s5_sgn_reg, INF32[30:0]};
        end else begin
            packed_res = {s5_sgn_reg, bits[30:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= s5_valid_reg;
        end
        out_result_reg <= packed_res;
    end

    assign fma_out.valid  = out_valid_reg;
    assign fma_out.result = out_result_reg;

endmodule

// ===== hdl/grouped_conv2d_same_pad.sv =====
// Channel  | Direction | Handshake            | Payload
// s_       | in        | s_valid / s_ready    | req_type, chan, group_in_chan, row, col, value
// m_       | out       | m_valid / m_ready    | out_chan, out_row, out_col, out_value
// cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Load transactions write the feature, weight or bias store.
// A compute transaction first looks up the group of out_chan (out_chan / out_per_group),
// then runs the accumulator loop once per tap (kernel_height * kernel_width * in_per_group
// taps) through the synchronous store read and the six-stage fused multiply-add; the
// result then moves into the output register.
// Reset (aresetn low, synchronous) restores the registers to 1,1,1,1,0,0,1,1 and clears
// the bias store; the feature and weight stores hold nothing defined until loaded.
// New transactions are taken while a result waits on m_; a finished pixel waits until
// the output register is free.
module grouped_conv2d_same_pad import gcsp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [3:0]  s_chan,
    input  logic [3:0]  s_group_in_chan,
    input  logic [5:0]  s_row,
    input  logic [5:0]  s_col,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_out_chan,
    output logic [5:0]  m_out_row,
    output logic [5:0]  m_out_col,
    output logic [31:0] m_out_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // configuration registers, held clamped
    logic [6:0] width_reg, height_reg;
    logic [2:0] kw_reg, kh_reg, pad_l_reg, pad_t_reg;
    logic [4:0] ipg_reg, opg_reg;

    logic [6:0] cfg7;
    logic [2:0] cfg3;
    logic [4:0] cfg5;

    assign cfg_ready = 1'b1;
    assign cfg7 = cfg_data[6:0];
    assign cfg3 = cfg_data[2:0];
    assign cfg5 = cfg_data[4:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 7'd1;
            height_reg <= 7'd1;
            kw_reg     <= 3'd1;
            kh_reg     <= 3'd1;
            pad_l_reg  <= 3'd0;
            pad_t_reg  <= 3'd0;
            ipg_reg    <= 5'd1;
            opg_reg    <= 5'd1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH: begin
                    width_reg <= (cfg7 == 7'd0) ? 7'd1 : (cfg7 > 7'(MAX_DIM)) ? 7'(MAX_DIM) : cfg7;
                end
                CFG_IMAGE_HEIGHT: begin
                    height_reg <= (cfg7 == 7'd0) ? 7'd1 : (cfg7 > 7'(MAX_DIM)) ? 7'(MAX_DIM) : cfg7;
                end
                CFG_KERNEL_WIDTH: begin
                    kw_reg <= (cfg3 == 3'd0) ? 3'd1 : cfg3;
                end
                CFG_KERNEL_HEIGHT: begin
                    kh_reg <= (cfg3 == 3'd0) ? 3'd1 : cfg3;
                end
                CFG_PAD_LEFT: begin
                    pad_l_reg <= (cfg3 > 3'(MAX_KERNEL - 1)) ? 3'(MAX_KERNEL - 1) : cfg3;
                end
                CFG_PAD_TOP: begin
                    pad_t_reg <= (cfg3 > 3'(MAX_KERNEL - 1)) ? 3'(MAX_KERNEL - 1) : cfg3;
                end
                CFG_IN_PER_GROUP: begin
                    ipg_reg <= (cfg5 == 5'd0) ? 5'd1
                             : (cfg5 > 5'(MAX_IN_CHANNELS)) ? 5'(MAX_IN_CHANNELS) : cfg5;
                end
                CFG_OUT_PER_GROUP: begin
                    opg_reg <= (cfg5 == 5'd0) ? 5'd1
                             : (cfg5 > 5'(MAX_OUT_CHANNELS)) ? 5'(MAX_OUT_CHANNELS) : cfg5;
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer state
    state_t state_reg, state_next;
    logic [3:0] ch_reg;
    logic [5:0] row_reg, col_reg;
    logic [4:0] rem_reg;
    logic [8:0] ic_base_reg;
    logic [2:0] r_reg, s_reg;
    logic [3:0] c_reg;
    logic [31:0] acc_reg;
    logic       tap_zero_reg;

    logic s_fire, m_fire, compute_ok, out_free;
    logic last_c, last_s, last_r, last_tap;
    fma_out_t fma_out;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign m_fire   = m_valid && m_ready;
    assign out_free = !m_valid || m_ready;
    assign compute_ok = (req_type_t'(s_req_type) == REQ_COMPUTE)
                     && ({1'b0, s_row} < height_reg) && ({1'b0, s_col} < width_reg);

    assign last_c   = ({1'b0, c_reg} == ipg_reg - 5'd1);
    assign last_s   = (s_reg == kw_reg - 3'd1);
    assign last_r   = (r_reg == kh_reg - 3'd1);
    assign last_tap = last_c && last_s && last_r;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && compute_ok) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (rem_reg < opg_reg) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_FEED;
            ST_FEED:  state_next = ST_WAIT;
            ST_WAIT: begin
                if (fma_out.valid) begin
                    state_next = last_tap ? ST_HOLD : ST_FETCH;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // tap address generation
    logic signed [8:0] ih, iw;
    logic [8:0]        ic;
    logic              tap_in;
    logic [FEAT_AW-1:0] feat_rd_addr, feat_wr_addr;
    logic [WGT_AW-1:0]  wgt_rd_addr, wgt_wr_addr;
    logic [31:0]        feat_rd_data, wgt_rd_data;
    logic               feat_we, wgt_we;

    always_comb begin
        ih = $signed({3'd0, row_reg}) + $signed({6'd0, r_reg}) - $signed({6'd0, pad_t_reg});
        iw = $signed({3'd0, col_reg}) + $signed({6'd0, s_reg}) - $signed({6'd0, pad_l_reg});
        ic = ic_base_reg + {5'd0, c_reg};
        tap_in = (ih >= 9'sd0) && (ih < $signed({2'd0, height_reg}))
              && (iw >= 9'sd0) && (iw < $signed({2'd0, width_reg}))
              && (ic < 9'(MAX_IN_CHANNELS));
        feat_rd_addr = {ic[3:0], ih[5:0], iw[5:0]};
        wgt_rd_addr  = wgt_addr(ch_reg, c_reg, r_reg, s_reg);
        feat_wr_addr = {s_chan, s_row, s_col};
        wgt_wr_addr  = wgt_addr(s_chan, s_group_in_chan, s_row[2:0], s_col[2:0]);
        feat_we = s_fire && (req_type_t'(s_req_type) == REQ_SAMPLE);
        wgt_we  = s_fire && (req_type_t'(s_req_type) == REQ_WEIGHT)
               && (s_row < 6'(MAX_KERNEL)) && (s_col < 6'(MAX_KERNEL));
    end

    gcsp_ram #(.DATA_W(32), .DEPTH(FEAT_DEPTH)) u_feat_ram (
        .aclk    (aclk),
        .wr_en   (feat_we),
        .wr_addr (feat_wr_addr),
        .wr_data (s_value),
        .rd_addr (feat_rd_addr),
        .rd_data (feat_rd_data)
    );

    gcsp_ram #(.DATA_W(32), .DEPTH(WGT_DEPTH)) u_wgt_ram (
        .aclk    (aclk),
        .wr_en   (wgt_we),
        .wr_addr (wgt_wr_addr),
        .wr_data (s_value),
        .rd_addr (wgt_rd_addr),
        .rd_data (wgt_rd_data)
    );

    // bias store: reset to zero
    logic [31:0] bias_reg [MAX_OUT_CHANNELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_OUT_CHANNELS; i++) begin
                bias_reg[i] <= 32'd0;
            end
        end else if (s_fire && req_type_t'(s_req_type) == REQ_BIAS) begin
            bias_reg[s_chan] <= s_value;
        end
    end

    gcsp_fma u_fma (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (state_reg == ST_FEED),
        .in_a     (wgt_rd_data),
        .in_b     (tap_zero_reg ? 32'd0 : feat_rd_data),
        .in_c     (acc_reg),
        .fma_out  (fma_out)
    );

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_fire) begin
            ch_reg      <= s_chan;
            row_reg     <= s_row;
            col_reg     <= s_col;
            rem_reg     <= {1'b0, s_chan};
            ic_base_reg <= 9'd0;
            r_reg       <= 3'd0;
            s_reg       <= 3'd0;
            c_reg       <= 4'd0;
            acc_reg     <= bias_reg[s_chan];
        end
        // group index by repeated subtraction; accumulate its channel base
        if (state_reg == ST_DIV && rem_reg >= opg_reg) begin
            rem_reg     <= rem_reg - opg_reg;
            ic_base_reg <= ic_base_reg + {4'd0, ipg_reg};
        end
        if (state_reg == ST_FETCH) begin
            tap_zero_reg <= !tap_in;
        end
        // take the sum and advance channel, then column, then row
        if (state_reg == ST_WAIT && fma_out.valid) begin
            acc_reg <= fma_out.result;
            if (!last_c) begin
                c_reg <= c_reg + 4'd1;
            end else begin
                c_reg <= 4'd0;
                if (!last_s) begin
                    s_reg <= s_reg + 3'd1;
                end else begin
                    s_reg <= 3'd0;
                    r_reg <= r_reg + 3'd1;
                end
            end
        end
    end

    // output register
    logic        m_valid_reg;
    logic [3:0]  m_chan_reg;
    logic [5:0]  m_row_reg, m_col_reg;
    logic [31:0] m_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_HOLD && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_fire) begin
            m_valid_reg <= 1'b0;
        end
        if (state_reg == ST_HOLD && out_free) begin
            m_chan_reg  <= ch_reg;
            m_row_reg   <= row_reg;
            m_col_reg   <= col_reg;
            m_value_reg <= acc_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_chan  = m_chan_reg;
    assign m_out_row   = m_row_reg;
    assign m_out_col   = m_col_reg;
    assign m_out_value = m_value_reg;

    // the adder only returns while the sequencer waits for it
    a_fma_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        fma_out.valid |-> state_reg == ST_WAIT)
        else $error("fma result outside wait state");

    // loop counters stay inside the configured kernel and group
    a_counters: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FETCH |-> (r_reg < kh_reg) && (s_reg < kw_reg)
                                  && ({1'b0, c_reg} < ipg_reg))
        else $error("tap counter out of range");

    // a finished pixel reaches the output register in the next cycle
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD && out_free) |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("finished pixel not delivered");

endmodule
